### hw/rtl/ptts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and codes of the periodic task table scheduler
// Request and response payloads, table entry layout, request/status/outcome
// codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ptts_pkg;

    // Table size and tick divider
    localparam int         DEF_SLOTS = 16;
    localparam int         DIV_W     = 9;
    localparam logic [8:0] DIV_RESET = 9'd392;

    // Request types
    localparam logic [2:0] REQ_ADD      = 3'd0;
    localparam logic [2:0] REQ_DELETE   = 3'd1;
    localparam logic [2:0] REQ_STATUS   = 3'd2;
    localparam logic [2:0] REQ_TIMER    = 3'd3;
    localparam logic [2:0] REQ_DISPATCH = 3'd4;
    localparam logic [2:0] REQ_COMPLETE = 3'd5;

    // Entry status codes
    localparam logic [1:0] ST_RUNNABLE = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_STOPPED  = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    // Outcome codes
    localparam logic [2:0] OC_OK          = 3'd0;
    localparam logic [2:0] OC_DUP         = 3'd1;
    localparam logic [2:0] OC_FULL        = 3'd2;
    localparam logic [2:0] OC_UNKNOWN     = 3'd3;
    localparam logic [2:0] OC_NONE_READY  = 3'd4;
    localparam logic [2:0] OC_NOT_RUNNING = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  task_id;
        logic [7:0]  period;
        logic [31:0] task_data;
        logic [3:0]  slot;
        logic        repeat_req;
    } t_req;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [1:0]  status_code;
        logic [3:0]  ready_slot;
        logic [7:0]  ready_id;
        logic [31:0] ready_data;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  ident;
        logic [7:0]  countdown;
        logic [7:0]  period;
        logic [1:0]  status;
        logic [31:0] word;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_RESET = '{
        ident:     8'd0,
        countdown: 8'd0,
        period:    8'd0,
        status:    ST_STOPPED,
        word:      32'd0
    };

    // Controller to datapath
    typedef struct packed {
        logic latch;       // capture the accepted request
        logic prescale;    // advance the prescaler
        logic scan_start;  // rewind the scan to slot 0
        logic rd_slot;     // point the scan at the request's slot
        logic scan_run;    // read one slot, check the previous one
        logic commit;      // write back the checked or chosen entry
        logic res_load;    // capture the response
        logic out_load;    // move the response to the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       slot_ok;
        logic       tick;
        logic       hit;
        logic       last;
        logic       out_free;
    } t_dp_sts;

endpackage

### hw/rtl/ptts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptts_ram
    import ptts_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = DEF_SLOTS
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ptts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_dp: scheduler datapath
// Task table in RAM with per-slot valid bits, slot scan behind the registered RAM
// read, prescaler, tick divider register, response and output registers.
// ----------------------------------------------------------------------------
module ptts_dp
    import ptts_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic             i_cfg_valid,
    input  logic [DIV_W-1:0] i_cfg_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_rsp             o_out_rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    t_req             r_req;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_pre;
    logic [CNT_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_chk_idx;
    logic             r_chk_vld;
    logic [SLOTS-1:0] r_valid;
    logic             r_dup;
    logic             r_free_vld;
    logic [IDX_W-1:0] r_free_idx;
    t_rsp             r_res;
    t_rsp             r_out;
    logic             r_out_vld;

    t_entry           s_ram_q;
    t_entry           s_row;
    t_entry           s_wdata;
    logic [IDX_W-1:0] s_waddr;
    logic             s_we;
    logic             s_match;
    logic             s_runnable;
    logic             s_running;
    logic             s_stopped;
    logic             s_cd_zero;
    logic             s_hit;
    logic             s_last;
    logic [DIV_W-1:0] s_pre_next;
    logic             s_tick;
    logic             s_out_free;
    t_rsp             s_res;

    // Entry table
    ptts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (s_ram_q)
    );

    // Checked row: a slot never written reads as its reset value
    assign s_row      = r_valid[r_chk_idx] ? s_ram_q : ENTRY_RESET;
    assign s_match    = (s_row.ident == r_req.task_id);
    assign s_runnable = (s_row.status == ST_RUNNABLE);
    assign s_running  = (s_row.status == ST_RUNNING);
    assign s_stopped  = (s_row.status == ST_STOPPED);
    assign s_cd_zero  = (s_row.countdown == 8'd0);

    // Prescaler step
    assign s_pre_next = r_pre + 1'b1;
    assign s_tick     = (s_pre_next == r_div);

    assign s_out_free = !r_out_vld || !i_out_stall;

    // Flag the checked row that the request acts on
    always_comb begin
        s_hit = 1'b0;
        if (r_chk_vld) begin
            unique case (r_req.req_type) inside
                REQ_DELETE, REQ_STATUS: s_hit = s_match;
                REQ_TIMER:              s_hit = s_runnable && !s_cd_zero;
                REQ_DISPATCH:           s_hit = s_runnable && s_cd_zero;
                REQ_COMPLETE:           s_hit = s_running;
                default:                s_hit = 1'b0;
            endcase
        end
    end

    assign s_last = r_chk_vld && ((r_req.req_type == REQ_COMPLETE) ||
                                  (r_chk_idx == IDX_W'(SLOTS - 1)));

    assign o_sts = '{
        op:       r_req.req_type,
        slot_ok:  (int'(r_req.slot) < SLOTS),
        tick:     s_tick,
        hit:      s_hit,
        last:     s_last,
        out_free: s_out_free
    };

    // Build the write-back entry
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_chk_idx;
        s_wdata = s_row;
        if (i_cmd.commit) begin
            unique case (r_req.req_type)
                REQ_ADD: begin
                    s_we    = !r_dup && r_free_vld;
                    s_waddr = r_free_idx;
                    s_wdata = '{
                        ident:     r_req.task_id,
                        countdown: r_req.period,
                        period:    r_req.period,
                        status:    ST_RUNNABLE,
                        word:      r_req.task_data
                    };
                end
                REQ_DELETE: begin
                    s_we           = 1'b1;
                    s_wdata.status = ST_STOPPED;
                end
                REQ_TIMER: begin
                    s_we              = 1'b1;
                    s_wdata.countdown = s_row.countdown - 8'd1;
                end
                REQ_DISPATCH: begin
                    s_we           = 1'b1;
                    s_wdata.status = ST_RUNNING;
                end
                REQ_COMPLETE: begin
                    s_we              = 1'b1;
                    s_wdata.countdown = s_row.period;
                    s_wdata.status    = r_req.repeat_req ? ST_RUNNABLE : ST_STOPPED;
                end
                default: s_we = 1'b0;
            endcase
        end
    end

    // Build the response
    always_comb begin
        s_res = '{
            outcome:     OC_OK,
            status_code: ST_RUNNABLE,
            ready_slot:  4'd0,
            ready_id:    8'd0,
            ready_data:  32'd0
        };
        unique case (r_req.req_type)
            REQ_ADD: begin
                if (r_dup) begin
                    s_res.outcome = OC_DUP;
                end else if (!r_free_vld) begin
                    s_res.outcome = OC_FULL;
                end
            end
            REQ_DELETE: begin
                if (!s_hit) begin
                    s_res.outcome = OC_UNKNOWN;
                end
            end
            REQ_STATUS: begin
                if (s_hit) begin
                    s_res.status_code = s_row.status;
                end else begin
                    s_res.outcome     = OC_UNKNOWN;
                    s_res.status_code = ST_ERROR;
                end
            end
            REQ_DISPATCH: begin
                if (s_hit) begin
                    s_res.ready_slot = 4'(r_chk_idx);
                    s_res.ready_id   = s_row.ident;
                    s_res.ready_data = s_row.word;
                end else begin
                    s_res.outcome = OC_NONE_READY;
                end
            end
            REQ_COMPLETE: begin
                if (!s_hit) begin
                    s_res.outcome = OC_NOT_RUNNING;
                end
            end
            default: s_res.outcome = OC_OK;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div      <= DIV_RESET;
            r_pre      <= '0;
            r_rd_idx   <= '0;
            r_chk_vld  <= 1'b0;
            r_valid    <= '0;
            r_dup      <= 1'b0;
            r_free_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            // Take a divider write
            if (i_cfg_valid) begin
                r_div <= i_cfg_data;
            end

            // Advance the prescaler, clear on a tick
            if (i_cmd.prescale) begin
                r_pre <= s_tick ? '0 : s_pre_next;
            end

            // Position and advance the scan
            if (i_cmd.scan_start) begin
                r_rd_idx   <= '0;
                r_dup      <= 1'b0;
                r_free_vld <= 1'b0;
            end else if (i_cmd.rd_slot) begin
                r_rd_idx <= CNT_W'(r_req.slot);
            end else if (i_cmd.scan_run && (r_rd_idx < CNT_W'(SLOTS))) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            r_chk_vld <= i_cmd.scan_run && (r_rd_idx < CNT_W'(SLOTS));

            // Track duplicates and the first free slot for an add
            if (r_chk_vld && (r_req.req_type == REQ_ADD)) begin
                if (s_match && (s_runnable || s_running)) begin
                    r_dup <= 1'b1;
                end
                if (s_stopped) begin
                    r_free_vld <= 1'b1;
                end
            end

            // Mark written slots
            if (s_we) begin
                r_valid[s_waddr] <= 1'b1;
            end

            // Output handshake
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.scan_run) begin
            r_chk_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (r_chk_vld && (r_req.req_type == REQ_ADD) && s_stopped && !r_free_vld) begin
            r_free_idx <= r_chk_idx;
        end
        if (i_cmd.res_load) begin
            r_res <= s_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

`ifndef NO_ASSERTIONS
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_we |-> (int'(s_waddr) < SLOTS))
        else $error("table write outside the slot range");

    a_chk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (int'(r_chk_idx) < SLOTS))
        else $error("checked slot outside the slot range");

    a_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.prescale && s_tick) |=> (r_pre == '0))
        else $error("prescaler not cleared after a tick");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || !i_out_stall))
        else $error("output register overwritten while held");
`endif

endmodule

### hw/rtl/ptts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ctrl: scheduler controller
// Sequences each request: accept, decode, slot scan, add write-back, and
// hand-off of the response to the output register.
// ----------------------------------------------------------------------------
module ptts_ctrl
    import ptts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_ADD_WR,
        S_OUT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_stall;
    t_dp_cmd s_cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        s_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    s_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (i_sts.op) inside
                    REQ_TIMER: begin
                        s_cmd.prescale = 1'b1;
                        if (i_sts.tick) begin
                            s_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end else begin
                            s_cmd.res_load = 1'b1;
                            n_state        = S_OUT;
                        end
                    end
                    REQ_COMPLETE: begin
                        if (i_sts.slot_ok) begin
                            s_cmd.rd_slot = 1'b1;
                            n_state       = S_SCAN;
                        end else begin
                            s_cmd.res_load = 1'b1;
                            n_state        = S_OUT;
                        end
                    end
                    REQ_ADD, REQ_DELETE, REQ_STATUS, REQ_DISPATCH: begin
                        s_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    default: begin
                        s_cmd.res_load = 1'b1;
                        n_state        = S_OUT;
                    end
                endcase
            end
            S_SCAN: begin
                s_cmd.scan_run = 1'b1;
                s_cmd.commit   = i_sts.hit;
                if (i_sts.hit && (i_sts.op != REQ_TIMER)) begin
                    // stop at the first match
                    s_cmd.res_load = 1'b1;
                    n_state        = S_OUT;
                end else if (i_sts.last) begin
                    if (i_sts.op == REQ_ADD) begin
                        n_state = S_ADD_WR;
                    end else begin
                        s_cmd.res_load = 1'b1;
                        n_state        = S_OUT;
                    end
                end
            end
            S_ADD_WR: begin
                s_cmd.commit   = 1'b1;
                s_cmd.res_load = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    s_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_stall;
    assign o_cmd      = s_cmd;

endmodule

### hw/rtl/periodic_task_table_scheduler.sv
// Requests without a scan go straight to the response register; complete reads only its
// own slot, a table scan reads up to SLOTS slots, and add follows its scan with a write-back.
// Throughput: one request at a time; the scan reads one slot per cycle from
// the single read port of the entry RAM. A new request enters while a result waits.
// Reset: synchronous, active low; all slots read as stopped at once, divide 392.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_table_scheduler: periodic task table scheduler top level
// Adds, deletes and queries periodic tasks, ticks their countdowns through
// a prescaler and dispatches and completes ready tasks.
// ----------------------------------------------------------------------------
module periodic_task_table_scheduler
    import ptts_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_rsp             o_out_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [DIV_W-1:0] i_cfg_data
);

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    // Request sequencing
    ptts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    // Table, prescaler and result path
    ptts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

    // Divider writes are always taken
    assign o_cfg_ready = 1'b1;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: periodic task table scheduler
// Drives add, delete, status, timer, dispatch and complete requests with
// random idle gaps on both channels and checks every response against a
// behavioral copy of the task table kept in the bench. The tick divider is
// rewritten between phases, and the run covers its extremes: zero, one and
// the top value.
// ----------------------------------------------------------------------------
module testbench
    import ptts_pkg::*;
;

    localparam int SLOTS          = DEF_SLOTS;
    localparam int RANDOM_ITEMS   = 160;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT       = 30;

    // Request codes that the block answers with a plain ok
    localparam logic [2:0] REQ_RESERVED_LO = 3'd6;
    localparam logic [2:0] REQ_RESERVED_HI = 3'd7;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_req             in_req    = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_rsp             out_rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [DIV_W-1:0] cfg_data  = '0;

    // Bench copy of the task table and prescaler
    logic [7:0]  tbl_ident  [SLOTS];
    logic [7:0]  tbl_count  [SLOTS];
    logic [7:0]  tbl_period [SLOTS];
    logic [1:0]  tbl_status [SLOTS];
    logic [31:0] tbl_word   [SLOTS];
    logic [8:0]  prescale;
    logic [8:0]  divide;

    t_rsp expected_rsp[$];
    int   mismatches   = 0;
    int   gap_max      = 18;
    int   stall_max    = 18;
    int   stall_left   = 0;
    int   hold_seq     = 0;
    int   hold_seen    = 0;
    int   quiet_cycles = 0;

    periodic_task_table_scheduler #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_rsp  (out_rsp),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Apply one request to the table copy and return the response it earns
    function automatic t_rsp schedule_request(input t_req r);
        t_rsp rsp;
        logic dup;
        logic done;
        rsp  = '0;
        dup  = 1'b0;
        done = 1'b0;
        case (r.req_type)
            REQ_ADD: begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_ident[i] == r.task_id &&
                        (tbl_status[i] == ST_RUNNABLE || tbl_status[i] == ST_RUNNING))
                        dup = 1'b1;
                if (dup) begin
                    rsp.outcome = OC_DUP;
                end else begin
                    rsp.outcome = OC_FULL;
                    for (int i = 0; i < SLOTS && !done; i++) begin
                        if (tbl_status[i] == ST_STOPPED) begin
                            tbl_ident[i]  = r.task_id;
                            tbl_count[i]  = r.period;
                            tbl_period[i] = r.period;
                            tbl_status[i] = ST_RUNNABLE;
                            tbl_word[i]   = r.task_data;
                            rsp.outcome   = OC_OK;
                            done          = 1'b1;
                        end
                    end
                end
            end
            REQ_DELETE: begin
                rsp.outcome = OC_UNKNOWN;
                for (int i = 0; i < SLOTS && !done; i++) begin
                    if (tbl_ident[i] == r.task_id) begin
                        tbl_status[i] = ST_STOPPED;
                        rsp.outcome   = OC_OK;
                        done          = 1'b1;
                    end
                end
            end
            REQ_STATUS: begin
                rsp.outcome     = OC_UNKNOWN;
                rsp.status_code = ST_ERROR;
                for (int i = 0; i < SLOTS && !done; i++) begin
                    if (tbl_ident[i] == r.task_id) begin
                        rsp.status_code = tbl_status[i];
                        rsp.outcome     = OC_OK;
                        done            = 1'b1;
                    end
                end
            end
            REQ_TIMER: begin
                prescale = prescale + 9'd1;
                if (prescale == divide) begin
                    prescale = '0;
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_status[i] == ST_RUNNABLE && tbl_count[i] != 8'd0)
                            tbl_count[i] = tbl_count[i] - 8'd1;
                end
            end
            REQ_DISPATCH: begin
                rsp.outcome = OC_NONE_READY;
                for (int i = 0; i < SLOTS && !done; i++) begin
                    if (tbl_status[i] == ST_RUNNABLE && tbl_count[i] == 8'd0) begin
                        tbl_status[i]  = ST_RUNNING;
                        rsp.outcome    = OC_OK;
                        rsp.ready_slot = 4'(i);
                        rsp.ready_id   = tbl_ident[i];
                        rsp.ready_data = tbl_word[i];
                        done           = 1'b1;
                    end
                end
            end
            REQ_COMPLETE: begin
                if (int'(r.slot) >= SLOTS || tbl_status[r.slot] != ST_RUNNING) begin
                    rsp.outcome = OC_NOT_RUNNING;
                end else begin
                    tbl_count[r.slot]  = tbl_period[r.slot];
                    tbl_status[r.slot] = r.repeat_req ? ST_RUNNABLE : ST_STOPPED;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic t_req pack_request(input logic [2:0] kind, input logic [7:0] id,
                                          input logic [7:0] per, input logic [31:0] data,
                                          input logic [3:0] sl, input logic rep);
        t_req r;
        r.req_type   = kind;
        r.task_id    = id;
        r.period     = per;
        r.task_data  = data;
        r.slot       = sl;
        r.repeat_req = rep;
        return r;
    endfunction

    // Request of the given kind with random content in every field
    function automatic t_req noise_request(input logic [2:0] kind);
        return pack_request(kind, 8'($urandom), 8'($urandom), $urandom,
                            4'($urandom), 1'($urandom));
    endfunction

    // Mostly well-formed traffic: a small id pool, short periods, completes aimed
    // at slots that are really running
    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   running[$];
        r = noise_request(REQ_ADD);
        if ($urandom_range(0, 3) != 0)
            r.task_id = 8'($urandom_range(0, 11));
        if ($urandom_range(0, 7) != 0)
            r.period = 8'($urandom_range(0, 4));
        pick = $urandom_range(0, 99);
        if (pick < 25)      r.req_type = REQ_ADD;
        else if (pick < 35) r.req_type = REQ_DELETE;
        else if (pick < 45) r.req_type = REQ_STATUS;
        else if (pick < 65) r.req_type = REQ_TIMER;
        else if (pick < 80) r.req_type = REQ_DISPATCH;
        else if (pick < 97) r.req_type = REQ_COMPLETE;
        else                r.req_type = (pick % 2) ? REQ_RESERVED_HI : REQ_RESERVED_LO;
        if (r.req_type == REQ_COMPLETE) begin
            for (int i = 0; i < SLOTS; i++)
                if (tbl_status[i] == ST_RUNNING)
                    running.push_back(i);
            if (running.size() != 0 && $urandom_range(0, 4) != 0)
                r.slot = 4'(running[$urandom_range(0, running.size() - 1)]);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Compare one accepted response with the oldest pending one
    task automatic check_response();
        t_rsp want;
        if (expected_rsp.size() == 0) begin
            report_mismatch("response with nothing pending, outcome",
                            32'(out_rsp.outcome), 32'd0);
        end else begin
            want = expected_rsp.pop_front();
            if (out_rsp.outcome !== want.outcome)
                report_mismatch("outcome", 32'(out_rsp.outcome), 32'(want.outcome));
            if (out_rsp.status_code !== want.status_code)
                report_mismatch("status_code", 32'(out_rsp.status_code),
                                32'(want.status_code));
            if (out_rsp.ready_slot !== want.ready_slot)
                report_mismatch("ready_slot", 32'(out_rsp.ready_slot),
                                32'(want.ready_slot));
            if (out_rsp.ready_id !== want.ready_id)
                report_mismatch("ready_id", 32'(out_rsp.ready_id), 32'(want.ready_id));
            if (out_rsp.ready_data !== want.ready_data)
                report_mismatch("ready_data", out_rsp.ready_data, want.ready_data);
        end
    endtask

    // Response side: check, then draw the stall before the next response
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                check_response();
            if (hold_seq != hold_seen) begin
                hold_seen  = hold_seq;
                stall_left = HOLD_CYCLES;
            end else if (out_valid && !out_stall) begin
                stall_left = $urandom_range(0, stall_max);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input t_req req);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        expected_rsp.push_back(schedule_request(req));
    endtask

    // Drop valid and wait until every pending response has come back
    task automatic drain_responses();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_rsp.size() != 0);
    endtask

    task automatic write_divide(input logic [DIV_W-1:0] value);
        drain_responses();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        divide = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Every request kind, field extremes, empty-slot id match, unknown requests
    task automatic test_basic_requests();
        gap_max = 18;
        send_request(pack_request(REQ_STATUS, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_STATUS, 8'hFF, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_DISPATCH, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_COMPLETE, 8'h00, 8'h00, 32'h0, 4'h0, 1'b1));
        send_request(pack_request(REQ_DELETE, 8'h80, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_ADD, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 1'b1));
        send_request(pack_request(REQ_ADD, 8'hFF, 8'h01, 32'h1234_5678, 4'h0, 1'b0));
        send_request(pack_request(REQ_ADD, 8'h00, 8'h01, 32'hA5A5_5A5A, 4'h0, 1'b0));
        send_request(pack_request(REQ_DISPATCH, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_TIMER, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_DISPATCH, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_STATUS, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        // Duplicate of a task that is running
        send_request(pack_request(REQ_ADD, 8'h00, 8'h07, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_COMPLETE, 8'h00, 8'h00, 32'h0, 4'hF, 1'b1));
        send_request(pack_request(REQ_COMPLETE, 8'h00, 8'h00, 32'h0, 4'h1, 1'b1));
        send_request(pack_request(REQ_TIMER, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 1'b1));
        send_request(pack_request(REQ_DISPATCH, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_COMPLETE, 8'h00, 8'h00, 32'h0, 4'h1, 1'b0));
        // Delete matches a stopped entry as well
        send_request(pack_request(REQ_DELETE, 8'hFF, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_DELETE, 8'hFF, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_RESERVED_LO, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 1'b1));
        send_request(pack_request(REQ_RESERVED_HI, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 1'b1));
        send_request(pack_request(REQ_ADD, 8'h3C, 8'h00, 32'h0, 4'hF, 1'b1));
        send_request(pack_request(REQ_DISPATCH, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_COMPLETE, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
    endtask

    // Fill every slot, overflow, dispatch all, then stop all again
    task automatic test_table_full();
        for (int i = 0; i < SLOTS; i++)
            send_request(pack_request(REQ_ADD, 8'(8'h40 + i), 8'h00, $urandom, 4'h0, 1'b0));
        send_request(pack_request(REQ_ADD, 8'h7E, 8'h05, $urandom, 4'h0, 1'b0));
        for (int i = 0; i < SLOTS; i++)
            send_request(pack_request(REQ_DISPATCH, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_ADD, 8'h7E, 8'h05, $urandom, 4'h0, 1'b0));
        send_request(pack_request(REQ_DISPATCH, 8'h00, 8'h00, 32'h0, 4'h0, 1'b0));
        send_request(pack_request(REQ_STATUS, 8'h4F, 8'h00, 32'h0, 4'h0, 1'b0));
        for (int i = SLOTS - 1; i >= 0; i--)
            send_request(pack_request(REQ_COMPLETE, 8'h00, 8'h00, 32'h0, 4'(i), 1'b0));
    endtask

    // Top divide: run the prescaler up close to its top without a tick
    task automatic test_lowered_divide();
        write_divide(9'd511);
        gap_max = 3;
        stall_max <= 3;
        send_request(pack_request(REQ_ADD, 8'h22, 8'h01, $urandom, 4'h0, 1'b0));
        for (int k = 0; k < 480; k++) begin
            send_request(noise_request(REQ_TIMER));
            if (k % 60 == 59) begin
                send_request(noise_request(REQ_DISPATCH));
                send_request(pack_request(REQ_COMPLETE, 8'h00, 8'h00, 32'h0, 4'h0, 1'b1));
            end
        end
    endtask

    // Divide zero written under the running count: the tick comes as the count wraps
    task automatic test_zero_divide();
        write_divide('0);
        for (int k = 0; k < 40; k++) begin
            send_request(noise_request(REQ_TIMER));
            if (k % 20 == 19) begin
                send_request(noise_request(REQ_DISPATCH));
                send_request(pack_request(REQ_COMPLETE, 8'h00, 8'h00, 32'h0, 4'h0, 1'b1));
            end
        end
        send_request(pack_request(REQ_DELETE, 8'h22, 8'h00, 32'h0, 4'h0, 1'b0));
    endtask

    // Long response hold-off while requests keep coming, then a full drain
    task automatic test_backpressure();
        write_divide(9'd2);
        gap_max = 0;
        stall_max <= 0;
        hold_seq <= hold_seq + 1;
        for (int k = 0; k < 30; k++)
            send_request(random_request());
        drain_responses();
        repeat (20) @(posedge clk);
    endtask

    // Random traffic in phases with different dividers and idle patterns
    task automatic test_random_traffic();
        logic [DIV_W-1:0] divides [4];
        divides = '{9'd511, 9'd1, 9'd3, 9'($urandom_range(2, 40))};
        for (int p = 0; p < 4; p++) begin
            write_divide(divides[p]);
            gap_max = (p % 2 == 0) ? 18 : 0;
            stall_max <= (p < 2) ? 18 : 0;
            for (int k = 0; k < RANDOM_ITEMS / 4; k++)
                send_request(random_request());
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_ident[i]  = '0;
            tbl_count[i]  = '0;
            tbl_period[i] = '0;
            tbl_status[i] = ST_STOPPED;
            tbl_word[i]   = '0;
        end
        prescale = '0;
        divide   = DIV_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_divide(9'd1);
        test_basic_requests();
        test_table_full();
        test_lowered_divide();
        test_zero_divide();
        test_backpressure();
        test_random_traffic();
        drain_responses();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
